>>> design/dot_matrix_row_port_controller_top_macros.svh
// Assertion macros for the dot-matrix row port controller.
`ifndef DOT_MATRIX_ROW_PORT_CONTROLLER_TOP_MACROS_SVH
`define DOT_MATRIX_ROW_PORT_CONTROLLER_TOP_MACROS_SVH
`ifndef SYNTH
// Gated by reset: disabled while rst_n is low.
`define DMRPC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked at every edge, reset included.
`define DMRPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DMRPC_ASSERT(lbl, clk, rstn, prop, msg)
`define DMRPC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> design/dmrpc_pkg.sv
// Package: types, port decode constants and field widths of the row port controller.
`timescale 1ns / 1ps
package dmrpc_pkg;

  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int BANK_W  = 3;
  localparam int ROW_W   = 4;
  localparam int DOTS_W  = 64;
  localparam int RLAT_W  = 32;
  localparam int POS_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PORT_WR   = 2'd0,
    CMD_PORT_RD   = 2'd1,
    CMD_HOST_CTL  = 2'd2,
    CMD_HOST_DATA = 2'd3
  } cmd_t;

  // port group decode
  localparam logic [BYTE_W-1:0] MASK_GROUP = 8'h84;
  localparam logic [BYTE_W-1:0] GRP_DOT    = 8'h00;
  localparam logic [BYTE_W-1:0] GRP_LATCH  = 8'h04;
  localparam logic [BYTE_W-1:0] GRP_CMD    = 8'h80;
  localparam logic [BYTE_W-1:0] GRP_OUT    = 8'h84;

  // latched output select
  localparam logic [BYTE_W-1:0] MASK_OUT     = 8'hdc;
  localparam logic [BYTE_W-1:0] OUT_BANK0    = 8'h84;
  localparam logic [BYTE_W-1:0] OUT_BANK1    = 8'h8c;
  localparam logic [BYTE_W-1:0] OUT_BANK2    = 8'h94;
  localparam logic [BYTE_W-1:0] OUT_BLANK    = 8'h9c;
  localparam logic [BYTE_W-1:0] OUT_STATUS   = 8'hc4;
  localparam logic [BYTE_W-1:0] OUT_ROW_DATA = 8'hcc;
  localparam logic [BYTE_W-1:0] OUT_ROW_CLK  = 8'hd4;
  localparam logic [BYTE_W-1:0] OUT_TEST     = 8'hdc;

  localparam logic [BYTE_W-1:0] READ_INVALID = 8'hff;
  localparam logic [BANK_W-1:0] BANK_RESET   = 3'd7;

  // bit k of a one-hot word's position is the OR over these positions
  localparam logic [RLAT_W-1:0] POS_MASK [POS_W] = '{
    32'haaaa_aaaa, 32'hcccc_cccc, 32'hf0f0_f0f0, 32'hff00_ff00, 32'hffff_0000
  };

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              busy_res;
    logic              status;
    logic [BANK_W-1:0] rom_bank;
    logic              reset_pulse;
    logic              row_event;
    logic              frame_done;
    logic [ROW_W-1:0]  row_index;
    logic              panel_side;
    logic              both_subframes;
    logic [DOTS_W-1:0] row_dots;
  } res_t;

endpackage

>>> design/dmrpc_if.sv
// Handshake interfaces for the input and result channels.
`timescale 1ns / 1ps
interface dmrpc_in_if import dmrpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] port_address;
  logic [BYTE_W-1:0] write_value;

  modport source (output valid, output cmd, output port_address, output write_value,
                  input ready);
  modport sink   (input valid, input cmd, input port_address, input write_value,
                  output ready);
endinterface

interface dmrpc_out_if import dmrpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_data;
  logic              busy_res;
  logic              status;
  logic [BANK_W-1:0] rom_bank;
  logic              reset_pulse;
  logic              row_event;
  logic              frame_done;
  logic [ROW_W-1:0]  row_index;
  logic              panel_side;
  logic              both_subframes;
  logic [DOTS_W-1:0] row_dots;

  modport source (output valid, output read_data, output busy_res, output status,
                  output rom_bank, output reset_pulse, output row_event, output frame_done,
                  output row_index, output panel_side, output both_subframes,
                  output row_dots, input ready);
  modport sink   (input valid, input read_data, input busy_res, input status,
                  input rom_bank, input reset_pulse, input row_event, input frame_done,
                  input row_index, input panel_side, input both_subframes,
                  input row_dots, output ready);
endinterface

>>> design/dot_matrix_row_port_controller_top.sv
// Top level: dot-matrix row port controller, input register, decode and result register.
//
//  channel | dir | handshake   | payload
//  in_ch   | in  | valid/ready | cmd, port_address, write_value
//  out_ch  | out | valid/ready | read_data, busy_res, status, rom_bank, reset_pulse,
//          |     |             | row_event, frame_done, row_index, panel_side,
//          |     |             | both_subframes, row_dots
//
// One item per cycle unless out_ch stalls; an item passes the input register, then the result register.
// The decode stage updates all board state as the item moves into the result register.
// rst_n is synchronous: state takes its power-on values at once, no clearing pass.
// A stalled result holds the result register; the input register takes one more item.
`timescale 1ns / 1ps
`include "dot_matrix_row_port_controller_top_macros.svh"
module dot_matrix_row_port_controller_top import dmrpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  dmrpc_in_if.sink   in_ch,
  dmrpc_out_if.source out_ch
);

  // pipeline control
  logic              s1_valid_r;
  logic [CMD_W-1:0]  s1_cmd_r;
  logic [BYTE_W-1:0] s1_addr_r;
  logic [BYTE_W-1:0] s1_val_r;
  logic              out_valid_r;
  res_t              res_r;
  res_t              res_nxt;
  logic              adv;
  logic              in_fire;
  logic              s1_fire;

  // board state
  logic [BYTE_W-1:0] pending_r, pending_nxt;
  logic [BYTE_W-1:0] latched_r, latched_nxt;
  logic [1:0]        host_ctl_r, host_ctl_nxt;
  logic              busy_r, busy_nxt;
  logic [BANK_W-1:0] bank_r, bank_nxt;
  logic              blank_r, blank_nxt;
  logic              status_r, status_nxt;
  logic              row_data_r, row_data_nxt;
  logic              row_clk_r, row_clk_nxt;
  logic              test_r, test_nxt;
  logic [RLAT_W-1:0] row_shift_r, row_shift_nxt;
  logic [RLAT_W-1:0] prev_row_r, prev_row_nxt;
  logic [DOTS_W-1:0] dot_sreg_r, dot_sreg_nxt;
  logic [DOTS_W-1:0] dot_hold_r, dot_hold_nxt;

  // decode temporaries
  logic              do_pw;
  logic [BYTE_W-1:0] pw_data;
  logic [BYTE_W-1:0] pair_sh;
  logic              bit_d;
  logic              row_upd;
  logic [RLAT_W-1:0] low_bit;
  logic [POS_W-1:0]  pos;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || adv;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign s1_fire     = s1_valid_r && adv;

  always_comb begin
    pending_nxt   = pending_r;
    latched_nxt   = latched_r;
    host_ctl_nxt  = host_ctl_r;
    busy_nxt      = busy_r;
    bank_nxt      = bank_r;
    blank_nxt     = blank_r;
    status_nxt    = status_r;
    row_data_nxt  = row_data_r;
    row_clk_nxt   = row_clk_r;
    test_nxt      = test_r;
    row_shift_nxt = row_shift_r;
    prev_row_nxt  = prev_row_r;
    dot_sreg_nxt  = dot_sreg_r;
    dot_hold_nxt  = dot_hold_r;
    res_nxt       = '0;
    do_pw         = 1'b0;
    pw_data       = s1_val_r;
    row_upd       = 1'b0;
    pair_sh       = '0;
    bit_d         = 1'b0;
    low_bit       = '0;
    pos           = '0;

    case (cmd_t'(s1_cmd_r))
      CMD_PORT_WR: begin
        do_pw = 1'b1;
      end
      CMD_PORT_RD: begin
        if ((s1_addr_r & MASK_GROUP) == GRP_CMD) begin
          busy_nxt          = 1'b0;
          res_nxt.read_data = latched_r;
        end else begin
          do_pw             = 1'b1;
          pw_data           = READ_INVALID;
          res_nxt.read_data = READ_INVALID;
        end
      end
      CMD_HOST_CTL: begin
        if (!host_ctl_r[0] && s1_val_r[0]) begin
          latched_nxt = pending_r;
          busy_nxt    = 1'b1;
        end
        if (host_ctl_r[1] && !s1_val_r[1]) begin
          // board reset; host side registers are kept
          res_nxt.reset_pulse = 1'b1;
          bank_nxt      = BANK_RESET;
          blank_nxt     = 1'b0;
          status_nxt    = 1'b0;
          row_data_nxt  = 1'b0;
          row_clk_nxt   = 1'b0;
          test_nxt      = 1'b1;
          row_shift_nxt = '0;
          prev_row_nxt  = '0;
          dot_sreg_nxt  = '0;
          dot_hold_nxt  = '0;
        end
        host_ctl_nxt = s1_val_r[1:0];
      end
      CMD_HOST_DATA: begin
        pending_nxt = s1_val_r;
      end
      default: begin
      end
    endcase

    if (do_pw) begin
      bit_d = pw_data[0];
      case (s1_addr_r & MASK_GROUP)
        GRP_DOT: begin
          pair_sh      = pw_data >> {s1_addr_r[1:0], 1'b0};
          dot_sreg_nxt = {dot_sreg_r[DOTS_W-3:0], pair_sh[1:0]};
        end
        GRP_LATCH: begin
          dot_hold_nxt = dot_sreg_r;
          row_upd      = 1'b1;
        end
        GRP_OUT: begin
          case (s1_addr_r & MASK_OUT)
            OUT_BANK0:    bank_nxt[0]  = ~bit_d;
            OUT_BANK1:    bank_nxt[1]  = ~bit_d;
            OUT_BANK2:    bank_nxt[2]  = ~bit_d;
            OUT_BLANK: begin
              blank_nxt = bit_d;
              row_upd   = 1'b1;
            end
            OUT_STATUS:   status_nxt   = bit_d;
            OUT_ROW_DATA: row_data_nxt = bit_d;
            OUT_ROW_CLK: begin
              if (row_clk_r && !bit_d) begin
                row_shift_nxt = {row_shift_r[RLAT_W-2:0], row_data_r};
              end
              row_clk_nxt = bit_d;
              row_upd     = 1'b1;
            end
            OUT_TEST: begin
              test_nxt = bit_d;
              if (!bit_d) begin
                busy_nxt = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end

    // row update: lowest set bit of the row latch picks row and side
    low_bit = row_shift_nxt & (~row_shift_nxt + 1'b1);
    for (int k = 0; k < POS_W; k++) begin
      pos[k] = |(low_bit & POS_MASK[k]);
    end
    if (row_upd && blank_nxt) begin
      if (row_shift_nxt != '0) begin
        res_nxt.row_event      = 1'b1;
        res_nxt.row_index      = pos[POS_W-1:1];
        res_nxt.panel_side     = pos[0];
        res_nxt.both_subframes = (prev_row_r != row_shift_nxt);
        res_nxt.row_dots       = dot_hold_nxt;
        prev_row_nxt           = row_shift_nxt;
      end else begin
        res_nxt.frame_done = 1'b1;
      end
    end

    res_nxt.busy_res = busy_nxt;
    res_nxt.status   = status_nxt;
    res_nxt.rom_bank = bank_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pending_r   <= '0;
      latched_r   <= '0;
      host_ctl_r  <= '0;
      busy_r      <= 1'b0;
      bank_r      <= BANK_RESET;
      blank_r     <= 1'b0;
      status_r    <= 1'b0;
      row_data_r  <= 1'b0;
      row_clk_r   <= 1'b0;
      test_r      <= 1'b1;
      row_shift_r <= '0;
      prev_row_r  <= '0;
      dot_sreg_r  <= '0;
      dot_hold_r  <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        pending_r   <= pending_nxt;
        latched_r   <= latched_nxt;
        host_ctl_r  <= host_ctl_nxt;
        busy_r      <= busy_nxt;
        bank_r      <= bank_nxt;
        blank_r     <= blank_nxt;
        status_r    <= status_nxt;
        row_data_r  <= row_data_nxt;
        row_clk_r   <= row_clk_nxt;
        test_r      <= test_nxt;
        row_shift_r <= row_shift_nxt;
        prev_row_r  <= prev_row_nxt;
        dot_sreg_r  <= dot_sreg_nxt;
        dot_hold_r  <= dot_hold_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_ch.cmd;
      s1_addr_r <= in_ch.port_address;
      s1_val_r  <= in_ch.write_value;
    end
    if (s1_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.read_data      = res_r.read_data;
  assign out_ch.busy_res       = res_r.busy_res;
  assign out_ch.status         = res_r.status;
  assign out_ch.rom_bank       = res_r.rom_bank;
  assign out_ch.reset_pulse    = res_r.reset_pulse;
  assign out_ch.row_event      = res_r.row_event;
  assign out_ch.frame_done     = res_r.frame_done;
  assign out_ch.row_index      = res_r.row_index;
  assign out_ch.panel_side     = res_r.panel_side;
  assign out_ch.both_subframes = res_r.both_subframes;
  assign out_ch.row_dots       = res_r.row_dots;

  `DMRPC_ASSERT(a_reset_defaults, clk, rst_n, (out_ch.valid && out_ch.reset_pulse) |-> (out_ch.rom_bank == BANK_RESET && !out_ch.status), "board reset item shows non-reset outputs")
  `DMRPC_ASSERT(a_row_or_frame, clk, rst_n, (s1_fire && res_nxt.row_event) |-> !res_nxt.frame_done, "row write and frame done in one item")
  `DMRPC_ASSERT(a_prev_row_follows, clk, rst_n, (s1_fire && res_nxt.row_event) |=> (prev_row_r == row_shift_r), "previous row latch not updated after row write")
  `DMRPC_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> (!out_ch.valid && in_ch.ready), "pipeline not empty after reset")

endmodule

>>> test/testbench.sv
// Self-checking testbench for the dot-matrix row port controller: directed table, then random.
`timescale 1ns / 1ps
module testbench;
  import dmrpc_pkg::*;

  localparam int RANDOM_ITEMS = 550;
  localparam int PHASE_ITEMS  = 138;
  localparam int HOLD_CYCLES  = 50;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;

  localparam logic [BYTE_W-1:0] OUT_SELS [8] = '{
    OUT_BANK0, OUT_BANK1, OUT_BANK2, OUT_BLANK,
    OUT_STATUS, OUT_ROW_DATA, OUT_ROW_CLK, OUT_TEST
  };

  typedef struct packed {
    cmd_t              op;
    logic [BYTE_W-1:0] addr;
    logic [BYTE_W-1:0] val;
    logic              typed;
    logic [BYTE_W-1:0] t_read;
    logic              t_busy;
    logic [BANK_W-1:0] t_bank;
  } stim_row_t;

  localparam int N_DIRECTED = 26;
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{CMD_PORT_RD,   8'h80, 8'h00, 1'b1, 8'h00, 1'b0, 3'd7},
    '{CMD_PORT_RD,   8'h00, 8'h00, 1'b1, 8'hff, 1'b0, 3'd7},
    '{CMD_PORT_WR,   8'h84, 8'h01, 1'b1, 8'h00, 1'b0, 3'd6},
    '{CMD_HOST_DATA, 8'h00, 8'hff, 1'b1, 8'h00, 1'b0, 3'd6},
    '{CMD_HOST_CTL,  8'h00, 8'h03, 1'b1, 8'h00, 1'b1, 3'd6},
    '{CMD_PORT_RD,   8'hbb, 8'h00, 1'b1, 8'hff, 1'b0, 3'd6},
    '{CMD_PORT_WR,   8'h80, 8'haa, 1'b1, 8'h00, 1'b0, 3'd6},
    '{CMD_PORT_WR,   8'h7b, 8'hc5, 1'b0, 8'h00, 1'b0, 3'd0},
    '{CMD_PORT_WR,   8'hcc, 8'h01, 1'b0, 8'h00, 1'b0, 3'd0},
    '{CMD_PORT_WR,   8'hd4, 8'h01, 1'b0, 8'h00, 1'b0, 3'd0},
    '{CMD_PORT_WR,   8'hd4, 8'h00, 1'b0, 8'h00, 1'b0, 3'd0},
    '{CMD_PORT_WR,   8'hcc, 8'h00, 1'b0, 8'h00, 1'b0, 3'd0},
    '{CMD_PORT_WR,   8'hd4, 8'hff, 1'b0, 8'h00, 1'b0, 3'd0},
    '{CMD_PORT_WR,   8'hf6, 8'hfe, 1'b0, 8'h00, 1'b0, 3'd0},
    '{CMD_PORT_WR,   8'h9c, 8'h01, 1'b0, 8'h00, 1'b0, 3'd0},
    '{CMD_PORT_WR,   8'h04, 8'h00, 1'b0, 8'h00, 1'b0, 3'd0},
    '{CMD_PORT_WR,   8'hcc, 8'h01, 1'b0, 8'h00, 1'b0, 3'd0},
    '{CMD_PORT_WR,   8'hd4, 8'h01, 1'b0, 8'h00, 1'b0, 3'd0},
    '{CMD_PORT_WR,   8'hd4, 8'h00, 1'b0, 8'h00, 1'b0, 3'd0},
    '{CMD_PORT_WR,   8'hc4, 8'h01, 1'b0, 8'h00, 1'b0, 3'd0},
    '{CMD_PORT_WR,   8'h8c, 8'h01, 1'b0, 8'h00, 1'b0, 3'd0},
    '{CMD_PORT_WR,   8'h94, 8'h00, 1'b0, 8'h00, 1'b0, 3'd0},
    '{CMD_PORT_WR,   8'hdc, 8'h00, 1'b0, 8'h00, 1'b0, 3'd0},
    '{CMD_HOST_CTL,  8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 3'd0},
    '{CMD_PORT_WR,   8'h9c, 8'h01, 1'b0, 8'h00, 1'b0, 3'd0},
    '{CMD_PORT_RD,   8'hff, 8'h00, 1'b0, 8'h00, 1'b0, 3'd0}
  };

  logic clk;
  logic rst_n;

  dmrpc_in_if  in_ch ();
  dmrpc_out_if out_ch ();

  dot_matrix_row_port_controller_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // board state as predicted
  logic [BYTE_W-1:0] cmd_pending, cmd_latched;
  logic [1:0]        host_ctl;
  logic              busy_ff, blank_on, status_ff, row_data_ff, row_clk_ff, test_ff;
  logic [BANK_W-1:0] bank_sel;
  logic [RLAT_W-1:0] row_bits, row_bits_prev;
  logic [DOTS_W-1:0] dot_sreg, dot_hold;

  res_t awaited_results [$];
  int   items_sent;
  int   mismatch_count;
  int   sender_idle_pct;
  int   recv_stall_pct;
  int   hold_requests;
  int   cycle_count;
  res_t got, want;

  function automatic void reset_board_model();
    bank_sel      = BANK_RESET;
    blank_on      = 1'b0;
    status_ff     = 1'b0;
    row_data_ff   = 1'b0;
    row_clk_ff    = 1'b0;
    test_ff       = 1'b1;
    row_bits      = '0;
    row_bits_prev = '0;
    dot_sreg      = '0;
    dot_hold      = '0;
  endfunction

  function automatic void update_row(inout res_t r);
    int pos;
    if (!blank_on) return;
    if (row_bits != '0) begin
      pos = 0;
      for (int i = RLAT_W - 1; i >= 0; i--) begin
        if (row_bits[i]) pos = i;
      end
      r.row_event      = 1'b1;
      r.row_index      = ROW_W'(pos >> 1);
      r.panel_side     = pos[0];
      r.both_subframes = (row_bits_prev != row_bits);
      r.row_dots       = dot_hold;
      row_bits_prev    = row_bits;
    end else begin
      r.frame_done = 1'b1;
    end
  endfunction

  function automatic void apply_port_write(logic [BYTE_W-1:0] addr, logic [BYTE_W-1:0] val,
                                           inout res_t r);
    logic [1:0] pair;
    logic       d;
    d = val[0];
    case (addr & MASK_GROUP)
      GRP_DOT: begin
        pair     = 2'((val >> (addr[1:0] * 2)) & 8'h03);
        dot_sreg = {dot_sreg[DOTS_W-3:0], pair};
      end
      GRP_LATCH: begin
        dot_hold = dot_sreg;
        update_row(r);
      end
      GRP_OUT: begin
        case (addr & MASK_OUT)
          OUT_BANK0:    bank_sel[0] = ~d;
          OUT_BANK1:    bank_sel[1] = ~d;
          OUT_BANK2:    bank_sel[2] = ~d;
          OUT_BLANK: begin
            blank_on = d;
            update_row(r);
          end
          OUT_STATUS:   status_ff = d;
          OUT_ROW_DATA: row_data_ff = d;
          OUT_ROW_CLK: begin
            if (row_clk_ff && !d) row_bits = {row_bits[RLAT_W-2:0], row_data_ff};
            row_clk_ff = d;
            update_row(r);
          end
          default: begin
            test_ff = d;
            if (!d) busy_ff = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
  endfunction

  function automatic res_t port_access_result(cmd_t op, logic [BYTE_W-1:0] addr,
                                              logic [BYTE_W-1:0] val);
    res_t r;
    r = '0;
    case (op)
      CMD_PORT_WR: apply_port_write(addr, val, r);
      CMD_PORT_RD: begin
        if ((addr & MASK_GROUP) == GRP_CMD) begin
          busy_ff     = 1'b0;
          r.read_data = cmd_latched;
        end else begin
          apply_port_write(addr, READ_INVALID, r);
          r.read_data = READ_INVALID;
        end
      end
      CMD_HOST_CTL: begin
        if (!host_ctl[0] && val[0]) begin
          cmd_latched = cmd_pending;
          busy_ff     = 1'b1;
        end
        if (host_ctl[1] && !val[1]) begin
          r.reset_pulse = 1'b1;
          reset_board_model();
        end
        host_ctl = val[1:0];
      end
      default: cmd_pending = val;
    endcase
    r.busy_res = busy_ff;
    r.status   = status_ff;
    r.rom_bank = bank_sel;
    return r;
  endfunction

  // called just after a falling edge; returns just after a falling edge once the item is taken
  task automatic send_item(input cmd_t op, input logic [BYTE_W-1:0] addr,
                           input logic [BYTE_W-1:0] val, input bit typed, input res_t fixed);
    res_t predicted;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= op;
    in_ch.port_address <= addr;
    in_ch.write_value  <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = port_access_result(op, addr, val);
    awaited_results.push_back(typed ? fixed : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic put(input cmd_t op, input logic [BYTE_W-1:0] addr,
                     input logic [BYTE_W-1:0] val);
    send_item(op, addr, val, 1'b0, '0);
  endtask

  function automatic logic [BYTE_W-1:0] out_port(logic [BYTE_W-1:0] sel);
    return sel | (BYTE_W'($urandom) & ~MASK_OUT);
  endfunction

  function automatic logic [BYTE_W-1:0] group_port(logic [BYTE_W-1:0] grp);
    return grp | (BYTE_W'($urandom) & ~MASK_GROUP);
  endfunction

  function automatic logic [BYTE_W-1:0] with_bit0(logic b);
    return (BYTE_W'($urandom) & 8'hfe) | BYTE_W'(b);
  endfunction

  task automatic row_clock_pulse();
    put(CMD_PORT_WR, out_port(OUT_ROW_CLK), with_bit0(1'b1));
    put(CMD_PORT_WR, out_port(OUT_ROW_CLK), with_bit0(1'b0));
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: random stalls plus one long hold-off
  initial begin : result_ready
    int holds_served;
    int hold_left;
    holds_served = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.read_data      = out_ch.read_data;
      got.busy_res       = out_ch.busy_res;
      got.status         = out_ch.status;
      got.rom_bank       = out_ch.rom_bank;
      got.reset_pulse    = out_ch.reset_pulse;
      got.row_event      = out_ch.row_event;
      got.frame_done     = out_ch.frame_done;
      got.row_index      = out_ch.row_index;
      got.panel_side     = out_ch.panel_side;
      got.both_subframes = out_ch.both_subframes;
      got.row_dots       = out_ch.row_dots;
      if (awaited_results.size() == 0) begin
        if (mismatch_count < 10) $display("unexpected item: %p", got);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (got.read_data !== want.read_data || got.busy_res !== want.busy_res ||
            got.status !== want.status || got.rom_bank !== want.rom_bank ||
            got.reset_pulse !== want.reset_pulse || got.row_event !== want.row_event ||
            got.frame_done !== want.frame_done || got.row_index !== want.row_index ||
            got.panel_side !== want.panel_side ||
            got.both_subframes !== want.both_subframes ||
            got.row_dots !== want.row_dots) begin
          if (mismatch_count < 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  exp: %p", want);
            $display("  got: %p", got);
          end
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[dot_matrix_row_port_controller_top] ERROR");
    $finish;
  end

  initial begin : stimulus
    res_t fixed;
    int   cur_phase;
    int   next_phase;
    int   pick;
    bit   hold_done;
    cmd_pending     = '0;
    cmd_latched     = '0;
    host_ctl        = '0;
    busy_ff         = 1'b0;
    reset_board_model();
    items_sent      = 0;
    mismatch_count  = 0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_requests   = 0;
    cycle_count     = 0;
    hold_done       = 1'b0;
    cur_phase       = 0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = CMD_PORT_WR;
    in_ch.port_address = '0;
    in_ch.write_value  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      fixed           = '0;
      fixed.read_data = directed_rows[i].t_read;
      fixed.busy_res  = directed_rows[i].t_busy;
      fixed.rom_bank  = directed_rows[i].t_bank;
      send_item(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].val,
                directed_rows[i].typed, fixed);
    end

    while (items_sent < N_DIRECTED + RANDOM_ITEMS) begin
      next_phase = (items_sent - N_DIRECTED) / PHASE_ITEMS;
      if (next_phase > 3) next_phase = 3;
      if (next_phase != cur_phase) begin
        // drain fully between phases
        in_ch.valid <= 1'b0;
        wait (awaited_results.size() == 0);
        @(negedge clk);
        cur_phase = next_phase;
        case (cur_phase)
          1:       begin sender_idle_pct = 68; recv_stall_pct = 0;  end
          2:       begin sender_idle_pct = 0;  recv_stall_pct = 68; end
          default: begin sender_idle_pct = 28; recv_stall_pct = 28; end
        endcase
      end
      if (!hold_done && items_sent - N_DIRECTED >= 40) begin
        hold_done = 1'b1;
        hold_requests++;
      end

      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // scan burst: blanking, optional new leading row bit, dot loads, latches, row clocks
        put(CMD_PORT_WR, out_port(OUT_BLANK), with_bit0($urandom_range(0, 4) != 0));
        if ($urandom_range(0, 3) == 0) begin
          put(CMD_PORT_WR, out_port(OUT_ROW_DATA), with_bit0(1'b1));
          row_clock_pulse();
          put(CMD_PORT_WR, out_port(OUT_ROW_DATA), with_bit0(1'b0));
        end
        repeat ($urandom_range(1, 8)) begin
          repeat ($urandom_range(0, 3))
            put(CMD_PORT_WR, group_port(GRP_DOT), BYTE_W'($urandom));
          if ($urandom_range(0, 1))
            put(CMD_PORT_WR, group_port(GRP_LATCH), BYTE_W'($urandom));
          row_clock_pulse();
        end
      end else if (pick < 45) begin
        put(CMD_PORT_WR, group_port(GRP_DOT), BYTE_W'($urandom));
      end else if (pick < 50) begin
        put(CMD_PORT_WR, group_port(GRP_LATCH), BYTE_W'($urandom));
      end else if (pick < 65) begin
        put(CMD_PORT_WR, out_port(OUT_SELS[$urandom_range(0, 7)]), BYTE_W'($urandom));
      end else if (pick < 75) begin
        if ($urandom_range(0, 1)) put(CMD_PORT_RD, group_port(GRP_CMD), BYTE_W'($urandom));
        else put(CMD_PORT_RD, BYTE_W'($urandom), BYTE_W'($urandom));
      end else if (pick < 84) begin
        put(CMD_HOST_CTL, BYTE_W'($urandom), BYTE_W'($urandom));
      end else if (pick < 90) begin
        put(CMD_HOST_DATA, BYTE_W'($urandom), BYTE_W'($urandom));
      end else begin
        put(cmd_t'($urandom_range(0, 3)), BYTE_W'($urandom), BYTE_W'($urandom));
      end
    end

    in_ch.valid <= 1'b0;
    wait (awaited_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[dot_matrix_row_port_controller_top] OK");
    end else begin
      $display("[dot_matrix_row_port_controller_top] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/dmrpc_pkg.sv
design/dmrpc_if.sv
design/dot_matrix_row_port_controller_top.sv
test/testbench.sv
